// File: src/rbd_pkg.sv
// Package for the run-length byte decoder: transaction payload types,
// decoder phase encoding and the literal header threshold. No dependencies.
package rbd_pkg;

  // Header values at or above this announce a literal run.
  localparam logic [7:0] HDR_LITERAL = 8'd128;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [6:0] repeat_count;
    logic       truncated;
  } out_item_t;

  // Result of decoding one byte: whether a result is produced, and its payload.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dec_res_t;

endpackage

// File: src/rle_byte_decoder_top.sv
// Top level of the run-length byte decoder: input register, decode step and
// result register with valid/stall handshakes. Uses rbd_pkg and rbd_core.
//
// This block decodes a PackBits-style compressed byte stream, one byte per
// input transaction. A header byte below 128 is a repeat count and the byte
// after it comes out once as a symbol carrying that count; a count of zero
// produces nothing. A header of 128 or more announces (header - 128) literal
// bytes, each of which comes out with a count of one. When the stream ends
// (end_of_stream set) right after a header that still needs payload, one
// result with symbol 0, count 0 and truncated set is produced; when it ends
// inside a literal run, the last literal carries truncated set. Each input
// byte yields zero or one result transaction. The block takes one byte every
// clock cycle when the output side is not stalled. A byte is captured in the
// input register and decoded in the following cycle against the phase and run
// count. Its result is loaded into the result register when the decode stage
// moves, and is presented from that register. The decode stage moves whenever
// the result register is empty or is being drained in the same cycle, so a
// result that is taken right away never holds back the next byte. Only a
// stalled result holds the byte waiting in the input register, and the input
// is then stalled until the result is taken.
module rle_byte_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rbd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbd_pkg::out_item_t out_data_o
);
  import rbd_pkg::*;

  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      advance;
  dec_res_t  dec_res;

  // The decode stage moves whenever the result register is empty or being
  // drained this cycle; it then either writes a result or writes nothing.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  rbd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid_q && advance),
    .item_i (in_data_q),
    .res_o  (dec_res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && dec_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && dec_res.valid) begin
      out_data_q <= dec_res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: src/rbd_core.sv
// Decode step of the run-length byte decoder: holds the phase and run count
// and turns one registered stream byte into at most one result. Uses rbd_pkg.
module rbd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  rbd_pkg::in_item_t item_i,
  output rbd_pkg::dec_res_t res_o
);
  import rbd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [6:0] remaining_q, remaining_d;
  logic [6:0] rem_dec;
  logic       is_literal_hdr;

  assign rem_dec        = remaining_q - 7'd1;
  assign is_literal_hdr = (item_i.data_byte >= HDR_LITERAL);

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    res_o       = '0;
    case (phase_q)
      PH_REPEAT: begin
        // A zero count consumes the payload byte without producing a result.
        res_o.valid             = (remaining_q != 7'd0);
        res_o.item.symbol       = item_i.data_byte;
        res_o.item.repeat_count = remaining_q;
        phase_d                 = PH_HEADER;
        remaining_d             = 7'd0;
      end
      PH_LITERAL: begin
        remaining_d             = rem_dec;
        if (rem_dec == 7'd0) begin
          phase_d = PH_HEADER;
        end
        res_o.valid             = 1'b1;
        res_o.item.symbol       = item_i.data_byte;
        res_o.item.repeat_count = 7'd1;
        res_o.item.truncated    = item_i.end_of_stream && (rem_dec != 7'd0);
      end
      default: begin
        // Header byte; the unused phase code behaves the same way.
        remaining_d = item_i.data_byte[6:0];
        if (!is_literal_hdr) begin
          phase_d = PH_REPEAT;
          if (item_i.end_of_stream) begin
            res_o.valid          = 1'b1;
            res_o.item.truncated = 1'b1;
          end
        end else if (item_i.data_byte[6:0] == 7'd0) begin
          phase_d = PH_HEADER;
        end else begin
          phase_d = PH_LITERAL;
          if (item_i.end_of_stream) begin
            res_o.valid          = 1'b1;
            res_o.item.truncated = 1'b1;
          end
        end
      end
    endcase
    if (item_i.end_of_stream) begin
      phase_d     = PH_HEADER;
      remaining_d = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      remaining_q <= 7'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
    end
  end

endmodule
